### src/ifs_pkg.sv
// Package for the inverse filterbank synthesis unit: shared types and constants.
// Depends on nothing; used by ifs_front, ifs_back and the top level.
package ifs_pkg;

  localparam logic REQ_COEFF  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [1:0] CFG_DELAYS   = 2'd0;
  localparam logic [1:0] CFG_CHANNELS = 2'd1;
  localparam logic [1:0] CFG_SHIFT    = 2'd2;

  // Table sizes follow from the 6-bit delay and channel indexes.
  localparam int unsigned MAX_DELAYS   = 64;
  localparam int unsigned MAX_CHANNELS = 64;
  localparam int unsigned TABLE_DEPTH  = MAX_DELAYS * MAX_CHANNELS;
  localparam int unsigned ADDR_W       = $clog2(TABLE_DEPTH);

  localparam int unsigned ACC_W = 64;

  // Frame job handed from the front to the back.
  typedef struct packed {
    logic [6:0] nd;
    logic [6:0] nc;
    logic [5:0] ring;
    logic [5:0] shift;
  } job_t;

endpackage

### src/ifs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ifs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### src/ifs_front.sv
// Front part: accepts items, writes the coefficient and history memories,
// clears them after reset and queues one job per completed frame. Uses ifs_pkg.
module ifs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic                 req_type_i,
  input  logic [5:0]           delay_index_i,
  input  logic [5:0]           channel_index_i,
  input  logic signed [23:0]   coeff_value_i,
  input  logic signed [15:0]   sample_value_i,
  input  logic [6:0]           delays_used_i,
  input  logic [6:0]           channels_used_i,
  input  logic [5:0]           output_shift_i,
  input  logic                 back_busy_i,
  output logic                 coeff_we_o,
  output logic                 hist_we_o,
  output logic [ifs_pkg::ADDR_W-1:0] waddr_o,
  output logic [23:0]          coeff_wdata_o,
  output logic [15:0]          hist_wdata_o,
  output logic                 job_valid_o,
  output ifs_pkg::job_t        job_o,
  input  logic                 job_take_i
);
  import ifs_pkg::*;

  localparam int unsigned Aw  = ADDR_W;
  localparam int unsigned Tot = TABLE_DEPTH;

  logic          clr_q, clr_d;
  logic [Aw:0]   clr_cnt_q, clr_cnt_d;
  logic [5:0]    ring_q, ring_d;
  logic          job_v_q, job_v_d;
  job_t          job_q, job_d;

  logic [6:0] nd, nc;
  logic [5:0] ring_eff;
  logic       acc_item, coeff_ok, samp_ok, last_ch;

  always_comb begin
    if (delays_used_i == 7'd0) nd = 7'd1;
    else if ({25'd0, delays_used_i} > MAX_DELAYS) nd = 7'(MAX_DELAYS);
    else nd = delays_used_i;
    if (channels_used_i == 7'd0) nc = 7'd1;
    else if ({25'd0, channels_used_i} > MAX_CHANNELS) nc = 7'(MAX_CHANNELS);
    else nc = channels_used_i;
  end

  assign ring_eff = ({1'b0, ring_q} >= nd) ? 6'd0 : ring_q;
  // Hold input while clearing, a job is queued, or the back is summing or waiting to store its result.
  assign full_o   = clr_q | job_v_q | back_busy_i;
  assign acc_item = push_i & ~full_o;
  assign coeff_ok = ({26'd0, delay_index_i} < MAX_DELAYS)
                  & ({26'd0, channel_index_i} < MAX_CHANNELS);
  assign samp_ok  = {1'b0, channel_index_i} < nc;
  assign last_ch  = {1'b0, channel_index_i} == (nc - 7'd1);

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    ring_d    = ring_q;
    job_v_d   = job_v_q & ~job_take_i;
    job_d     = job_q;
    coeff_we_o = 1'b0;
    hist_we_o  = 1'b0;
    coeff_wdata_o = coeff_value_i;
    hist_wdata_o  = sample_value_i;
    waddr_o = Aw'(delay_index_i) * Aw'(MAX_CHANNELS) + Aw'(channel_index_i);
    if (clr_q) begin
      coeff_we_o = 1'b1;
      hist_we_o  = 1'b1;
      coeff_wdata_o = '0;
      hist_wdata_o  = '0;
      waddr_o = clr_cnt_q[Aw-1:0];
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == (Aw+1)'(Tot-1)) clr_d = 1'b0;
    end else if (acc_item) begin
      if (req_type_i == REQ_COEFF) begin
        coeff_we_o = coeff_ok;
      end else if (samp_ok) begin
        hist_we_o = 1'b1;
        waddr_o   = Aw'(ring_eff) * Aw'(MAX_CHANNELS) + Aw'(channel_index_i);
        ring_d    = ring_eff;
        if (last_ch) begin
          job_v_d = 1'b1;
          job_d   = '{nd: nd, nc: nc, ring: ring_eff, shift: output_shift_i};
          ring_d  = ({1'b0, ring_eff} + 7'd1 >= nd) ? 6'd0 : ring_eff + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      ring_q    <= '0;
      job_v_q   <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      ring_q    <= ring_d;
      job_v_q   <= job_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = job_v_q;
  assign job_o       = job_q;

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !acc_item) else $error("item taken during clear");
  a_no_job_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_v_q && !job_take_i |=> job_v_q) else $error("job lost");
  a_ring_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_v_q |-> {1'b0, job_q.ring} < job_q.nd) else $error("ring out of range");
endmodule

### src/ifs_back.sv
// Back part: sequences the multiply-accumulate over delays and channels,
// shifts, saturates and holds the result in a one-entry output register.
// Uses ifs_pkg.
module ifs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  ifs_pkg::job_t        job_i,
  output logic                 job_take_o,
  output logic                 busy_o,
  output logic [ifs_pkg::ADDR_W-1:0] coeff_raddr_o,
  output logic [ifs_pkg::ADDR_W-1:0] hist_raddr_o,
  input  logic signed [23:0]   coeff_rdata_i,
  input  logic signed [15:0]   hist_rdata_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic signed [31:0]   synth_value_o,
  output logic                 saturated_o
);
  import ifs_pkg::*;

  localparam int unsigned Aw = ADDR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  st_q, st_d;
  job_t        job_q;
  logic [6:0]  d_q, d_d, k_q, k_d;
  logic [5:0]  slot_q, slot_d;
  logic        rv_q, rv_d;     // read data valid next cycle
  logic        pv_q;           // product register valid
  logic signed [39:0] prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, shifted;
  logic        ov_q, ov_d;
  logic signed [31:0] val_q, val_d;
  logic        sat_q, sat_d;

  assign coeff_raddr_o = Aw'(d_q) * Aw'(MAX_CHANNELS) + Aw'(k_q);
  assign hist_raddr_o  = Aw'(slot_q) * Aw'(MAX_CHANNELS) + Aw'(k_q);
  assign job_take_o = (st_q == S_IDLE) & job_valid_i;
  assign busy_o     = (st_q != S_IDLE);
  assign shifted    = acc_q >>> job_q.shift;

  always_comb begin
    st_d = st_q; d_d = d_q; k_d = k_q; slot_d = slot_q; rv_d = 1'b0;
    acc_d = acc_q; ov_d = ov_q & ~pop_i; val_d = val_q; sat_d = sat_q;
    if (pv_q) acc_d = acc_q + ACC_W'(prod_q);
    case (st_q)
      S_IDLE: begin
        if (job_take_o) begin
          st_d = S_RUN; d_d = '0; k_d = '0; slot_d = job_i.ring; acc_d = '0;
        end
      end
      S_RUN: begin
        rv_d = 1'b1;
        if (k_q + 7'd1 < job_q.nc) begin
          k_d = k_q + 7'd1;
        end else begin
          k_d = '0;
          // Step the ring back one frame per delay.
          slot_d = (slot_q == 6'd0) ? 6'(job_q.nd - 7'd1) : slot_q - 6'd1;
          if (d_q + 7'd1 < job_q.nd) d_d = d_q + 7'd1;
          else st_d = S_LAST;
        end
      end
      S_LAST: st_d = S_FIN;
      S_FIN: begin
        if (!pv_q && !rv_q) st_d = S_OUT;
      end
      S_OUT: begin
        // Hold the finished sum while the previous result still waits.
        if (!ov_q) begin
          if (shifted > 64'sd2147483647) begin
            val_d = 32'sh7fffffff; sat_d = 1'b1;
          end else if (shifted < -64'sd2147483648) begin
            val_d = 32'sh80000000; sat_d = 1'b1;
          end else begin
            val_d = shifted[31:0]; sat_d = 1'b0;
          end
          ov_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      rv_q <= 1'b0;
      pv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      rv_q <= rv_d;
      pv_q <= rv_q;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) job_q <= job_i;
    d_q <= d_d; k_q <= k_d; slot_q <= slot_d;
    prod_q <= coeff_rdata_i * hist_rdata_i;
    acc_q <= acc_d; val_q <= val_d; sat_q <= sat_d;
  end

  assign empty_o       = ~ov_q;
  assign synth_value_o = val_q;
  assign saturated_o   = sat_q;

  a_sat_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && sat_q |-> (val_q == 32'sh7fffffff || val_q == 32'sh80000000))
    else $error("clipped result not at a bound");
  a_no_out_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !pop_i |=> ov_q && $stable(val_q)) else $error("result overwritten");
  a_pipe_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT) |-> !pv_q && !rv_q) else $error("sum not drained");
endmodule

### src/inverse_filterbank_synthesis_unit.sv
// Top level of the inverse filterbank synthesis unit: register file, memories,
// front and back parts. Depends on ifs_pkg, ifs_ram, ifs_front, ifs_back.
//
// Channel   Direction  Handshake         Payload
// input     in         push_i / full_o   req_type, delay/channel index, coeff, sample
// result    out        empty_o / pop_i   synth_value, saturated
// config    in         cfg_valid_i/ready cfg_index_i, cfg_data_i
//
// A coefficient load or a sample that does not close a frame leaves the input
// open. A frame-closing sample starts a sum of N = delays_used*channels_used
// products (each factor clamped to 1..64) on one shared multiply-accumulate
// unit; the result shows up and the input opens again once the sum is done,
// with full_o high in between. If an older result still sits in the output
// register, the finished sum is held (input still stalled) until that result
// is popped. After reset both memories are cleared, one entry per cycle over
// all 4096 entries, with full_o held high.
module inverse_filterbank_synthesis_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic                req_type_i,
  input  logic [5:0]          delay_index_i,
  input  logic [5:0]          channel_index_i,
  input  logic signed [23:0]  coeff_value_i,
  input  logic signed [15:0]  sample_value_i,
  output logic                empty_o,
  input  logic                pop_i,
  output logic signed [31:0]  synth_value_o,
  output logic                saturated_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [6:0]          cfg_data_i
);
  import ifs_pkg::*;

  localparam int unsigned Depth = TABLE_DEPTH;
  localparam int unsigned Aw    = ADDR_W;

  logic [6:0] delays_q, channels_q;
  logic [5:0] shift_q;

  // Config writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delays_q   <= 7'd1;
      channels_q <= 7'd64;
      shift_q    <= 6'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DELAYS:   delays_q   <= cfg_data_i;
        CFG_CHANNELS: channels_q <= cfg_data_i;
        CFG_SHIFT:    shift_q    <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  logic          coeff_we, hist_we, back_busy, job_valid, job_take;
  logic [Aw-1:0] waddr, coeff_raddr, hist_raddr;
  logic [23:0]   coeff_wdata, coeff_rdata;
  logic [15:0]   hist_wdata, hist_rdata;
  job_t          job;

  ifs_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .req_type_i, .delay_index_i,
    .channel_index_i, .coeff_value_i, .sample_value_i,
    .delays_used_i(delays_q), .channels_used_i(channels_q),
    .output_shift_i(shift_q), .back_busy_i(back_busy),
    .coeff_we_o(coeff_we), .hist_we_o(hist_we), .waddr_o(waddr),
    .coeff_wdata_o(coeff_wdata), .hist_wdata_o(hist_wdata),
    .job_valid_o(job_valid), .job_o(job), .job_take_i(job_take)
  );

  ifs_ram #(.Width(24), .Depth(Depth)) u_coeff_ram (
    .clk_i, .we_i(coeff_we), .waddr_i(waddr), .wdata_i(coeff_wdata),
    .raddr_i(coeff_raddr), .rdata_o(coeff_rdata)
  );

  ifs_ram #(.Width(16), .Depth(Depth)) u_hist_ram (
    .clk_i, .we_i(hist_we), .waddr_i(waddr), .wdata_i(hist_wdata),
    .raddr_i(hist_raddr), .rdata_o(hist_rdata)
  );

  ifs_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job),
    .job_take_o(job_take), .busy_o(back_busy),
    .coeff_raddr_o(coeff_raddr), .hist_raddr_o(hist_raddr),
    .coeff_rdata_i(coeff_rdata), .hist_rdata_i(hist_rdata),
    .empty_o, .pop_i, .synth_value_o, .saturated_o
  );

  a_job_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> full_o) else $error("input open with job queued");
  a_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i && !empty_o |=> empty_o) else $error("result repeated");
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(synth_value_o) && $stable(saturated_o))
    else $error("waiting result changed");
endmodule
